FILE: design/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg: shared types for the indexed insert/delete list
// Command and status codes, transaction payload structs and the control
// word that the top level broadcasts along the row of list cells.
// ----------------------------------------------------------------------------
package iidl_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int ITEM_W  = 32;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_APPEND = 3'd5,
        CMD_POP    = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // What every cell does with its entry at a clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_WRITE  = 3'd3,
        CELL_APPEND = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic               rd_tail;
        logic [POS_W-1:0]   pos;
    } t_cell_ctl;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [ITEM_W-1:0]  item_value;
    } t_in_item;

    typedef struct packed {
        logic [ITEM_W-1:0]  read_value;
        logic [POS_W-1:0]   found_position;
        t_status            status;
        logic [CNT_W-1:0]   entry_count;
    } t_out_item;

endpackage

FILE: design/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list: ordered list with indexed insert and remove
// A row of DEPTH cells holds the list; each command edits all cells together.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (i_in_valid, o_in_stall, i_in_data)
// and every command returns exactly one result transaction on the output
// channel (o_out_valid, i_out_stall, o_out_data). A transaction moves at a
// rising edge where valid is high and stall is low.
// The result of a command accepted at one edge is registered and presented
// from that edge on. Throughput is one command per cycle while the receiver
// does not stall, set by the list cells, which all shift, hold or load
// together, and by the single output register that carries the result.
// When the receiver stalls, the result stays in the output register and
// o_in_stall rises, so no further command is taken until that result leaves.
// Reset (i_rst_n low at a clock edge) empties the list and drops any
// pending result. Entry contents are not cleared; the count alone decides
// which entries are visible, so nothing stale is ever returned.
// Error cases (full list, index out of range, no match) are reported in the
// status field and leave the list untouched.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list
    import iidl_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam int XW = $clog2(DEPTH);

    // List occupancy and the output register.
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    t_out_item              r_out_data;
    t_out_item              n_out_data;

    logic                   w_in_fire;
    t_cell_ctl              w_ctl;
    logic [63:0]            w_in_wide;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_cell_val [DEPTH];
    logic [VALUE_WIDTH-1:0] w_cell_rd  [DEPTH];
    logic [DEPTH-1:0]       w_match;
    logic [VALUE_WIDTH-1:0] w_rd_or;
    logic [63:0]            w_rd_wide;
    logic                   w_found;
    logic [XW-1:0]          w_found_idx;
    logic                   w_full;
    logic                   w_pos_gt_cnt;
    logic                   w_pos_ge_cnt;

    // A new command may enter whenever the output register is free or its
    // result leaves in this same cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // Values are kept in VALUE_WIDTH bits.
    assign w_in_wide = 64'(i_in_data.item_value);
    assign w_val     = w_in_wide[VALUE_WIDTH-1:0];

    assign w_full       = (r_count == CW'(DEPTH));
    assign w_pos_gt_cnt = (IW'(i_in_data.position) >  IW'(r_count));
    assign w_pos_ge_cnt = (IW'(i_in_data.position) >= IW'(r_count));

    // The row of cells. Each cell sees its neighbors' entries so an insert
    // ripples data one slot up and a remove one slot down, all cells together.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell_val[g+1];
        end

        iidl_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_val     (w_val),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_value   (w_cell_val[g]),
            .o_rd_data (w_cell_rd[g]),
            .o_match   (w_match[g])
        );
    end

    // At most one cell drives nonzero read data, so an OR collects it.
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_or = w_rd_or | w_cell_rd[i];
        end
    end

    assign w_rd_wide = 64'(w_rd_or);

    iidl_first #(
        .DEPTH (DEPTH)
    ) u_first (
        .i_match (w_match),
        .o_found (w_found),
        .o_index (w_found_idx)
    );

    // Command decode: picks the cell operation, the new count and the
    // result fields. Nothing changes unless a command is accepted.
    always_comb begin
        w_ctl.op      = CELL_HOLD;
        w_ctl.rd_tail = 1'b0;
        w_ctl.pos     = i_in_data.position;
        n_count       = r_count;
        n_out_data.read_value     = '0;
        n_out_data.found_position = '0;
        n_out_data.status         = ST_OK;

        unique case (i_in_data.cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_out_data.status = ST_FULL;
                end else if (w_pos_gt_cnt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    w_ctl.op = CELL_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_pos_ge_cnt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    w_ctl.op = CELL_REMOVE;
                    n_count  = r_count - CW'(1);
                    n_out_data.read_value = w_rd_wide[ITEM_W-1:0];
                end
            end
            CMD_READ: begin
                if (w_pos_ge_cnt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    n_out_data.read_value = w_rd_wide[ITEM_W-1:0];
                end
            end
            CMD_WRITE: begin
                if (w_pos_ge_cnt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    w_ctl.op = CELL_WRITE;
                end
            end
            CMD_FIND: begin
                if (w_found) begin
                    n_out_data.found_position = POS_W'(w_found_idx);
                end else begin
                    n_out_data.status = ST_MISS;
                end
            end
            CMD_APPEND: begin
                if (w_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_APPEND;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                // The tail entry needs no shifting; dropping the count
                // removes it.
                w_ctl.rd_tail = 1'b1;
                if (r_count == '0) begin
                    n_out_data.status = ST_MISS;
                end else begin
                    n_count = r_count - CW'(1);
                    n_out_data.read_value = w_rd_wide[ITEM_W-1:0];
                end
            end
            default: begin
                n_out_data.status = ST_OK;
            end
        endcase

        if (!w_in_fire) begin
            w_ctl.op = CELL_HOLD;
            n_count  = r_count;
        end
        n_out_data.entry_count = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count exceeds capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("accepted command produced no result");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.entry_count == CNT_W'(r_count)))
        else $error("pending result count disagrees with list count");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_in_fire) |=> $stable(r_count))
        else $error("list count changed without a command");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == ST_FULL)) |-> w_full)
        else $error("full status reported for a list that is not full");
`endif

endmodule

FILE: design/iidl_cell.sv
// ----------------------------------------------------------------------------
// iidl_cell: one list slot
// Holds one entry and decides from its own index whether to hold, take its
// lower neighbor, take its upper neighbor or load the command value.
// ----------------------------------------------------------------------------
module iidl_cell
    import iidl_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX       = 0
) (
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [VALUE_WIDTH-1:0]     i_val,
    input  logic [VALUE_WIDTH-1:0]     i_left,
    input  logic [VALUE_WIDTH-1:0]     i_right,
    output logic [VALUE_WIDTH-1:0]     o_value,
    output logic [VALUE_WIDTH-1:0]     o_rd_data,
    output logic                       o_match
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   w_is_pos;
    logic                   w_above_pos;
    logic                   w_is_cnt;
    logic                   w_is_tail;
    logic                   w_held;

    assign w_is_pos    = (IW'(INDEX) == IW'(i_ctl.pos));
    assign w_above_pos = (IW'(INDEX) >  IW'(i_ctl.pos));
    assign w_is_cnt    = (CW'(INDEX) == i_count);
    assign w_is_tail   = (CW'(INDEX + 1) == i_count);
    assign w_held      = (CW'(INDEX) < i_count);

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (w_is_pos) begin
                    n_value = i_val;
                end else if (w_above_pos) begin
                    n_value = i_left;
                end
            end
            CELL_REMOVE: begin
                if (w_is_pos || w_above_pos) begin
                    n_value = i_right;
                end
            end
            CELL_WRITE: begin
                if (w_is_pos) begin
                    n_value = i_val;
                end
            end
            CELL_APPEND: begin
                if (w_is_cnt) begin
                    n_value = i_val;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value   = r_value;
    assign o_rd_data = ((i_ctl.rd_tail ? w_is_tail : w_is_pos)) ? r_value : '0;
    assign o_match   = w_held && (r_value == i_val);

endmodule

FILE: design/iidl_first.sv
// ----------------------------------------------------------------------------
// iidl_first: first-match encoder
// Isolates the lowest set match flag and encodes its index.
// ----------------------------------------------------------------------------
module iidl_first
    import iidl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]         i_match,
    output logic                     o_found,
    output logic [$clog2(DEPTH)-1:0] o_index
);

    localparam int XW = $clog2(DEPTH);

    logic [DEPTH-1:0] w_lowest;

    // Two's complement trick keeps only the lowest set bit.
    assign w_lowest = i_match & (~i_match + DEPTH'(1));
    assign o_found  = |i_match;

    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_lowest[i]) begin
                o_index = o_index | XW'(i);
            end
        end
    end

endmodule
